// ===== hdl/cmli_pkg.sv =====
`default_nettype none

package cmli_pkg;

    // One packed RGBA color, red in the top byte.
    typedef logic [31:0] t_rgba;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_PALETTE_SIZE = 3'd0;
    localparam t_cfg_index CFG_CLIP_UNDER   = 3'd1;
    localparam t_cfg_index CFG_CLIP_OVER    = 3'd2;
    localparam t_cfg_index CFG_UNDER_COLOR  = 3'd3;
    localparam t_cfg_index CFG_OVER_COLOR   = 3'd4;
    localparam t_cfg_index CFG_MASK_COLOR   = 3'd5;

    // Opaque black, used for an empty palette and as the color reset value.
    localparam t_rgba OPAQUE_BLACK = 32'h0000_00FF;

    // Fixed field widths.
    localparam int SAMPLE_W = 20;
    localparam int SIZE_W   = 9;
    localparam int ENTRY_W  = 8;

    // Output word buffer: holds every result in flight, so the pipeline never stalls.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

endpackage

`default_nettype wire

// ===== hdl/color_map_interpolated_lookup.sv =====
// Interpolating color-map lookup.
//
// Input channel (i_valid / o_stall): a word is taken at a rising edge where
// i_valid is high and o_stall is low. A write word (cmd 0) stores entry_color
// at entry_index in the palette and gives no result. A map word (cmd 1) gives
// exactly one RGBA result word on the output channel (o_valid / i_stall).
// Configuration registers are written via i_cfg_valid / o_cfg_ready, i_cfg_index
// and i_cfg_data, by the user only while no map word is in flight; not enforced.
//
// A map word accepted at the input passes through stage 1, stage 2 (palette
// read), stage 3 and the output buffer. Throughput is one word per clock while
// o_stall is low, read and write words alike; the palette RAM has a write port
// and two read ports, so both neighbors of a blend are fetched together.
//
// Reset clears the configuration to its reset values and empties the
// pipeline and the output buffer; palette contents are undefined until
// written. When the receiver stalls, up to eight results are held in the
// output buffer; o_stall rises once eight map words are outstanding.
`default_nettype none

module color_map_interpolated_lookup #(
    parameter int PALETTE_DEPTH = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration write channel.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire cmli_pkg::t_cfg_index        i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data,
    // Input words.
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_cmd,
    input  wire logic signed [19:0]          i_sample,
    input  wire logic                        i_not_finite,
    input  wire logic [7:0]                  i_entry_index,
    input  wire logic [31:0]                 i_entry_color,
    // Result words.
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue,
    output logic [7:0]                       o_alpha
);

    localparam int F        = FRACTION_BITS;
    localparam int AW       = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW       = (F + 2 > cmli_pkg::SAMPLE_W + 1) ? F + 2
                                                               : cmli_pkg::SAMPLE_W + 1;
    localparam int PW       = F + 1 + cmli_pkg::SIZE_W;
    localparam int SIZE_LIM = (PALETTE_DEPTH > 511) ? 511 : PALETTE_DEPTH;
    localparam int SW       = F + 11;

    localparam logic signed [CW-1:0] ONE_C   = CW'(1) << F;
    localparam logic [F:0]           ONE_U   = (F + 1)'(1) << F;
    localparam logic signed [SW-1:0] HALF_C  = SW'(1) << (F - 1);
    localparam logic [12:0]          DEPTH_C = 13'(PALETTE_DEPTH);
    localparam logic [8:0]           LIM_C   = 9'(SIZE_LIM);

    // Configuration registers.
    logic [8:0]          r_palette_size;
    logic                r_clip_under;
    logic                r_clip_over;
    cmli_pkg::t_rgba     r_under_color;
    cmli_pkg::t_rgba     r_over_color;
    cmli_pkg::t_rgba     r_mask_color;

    // Palette memory.
    cmli_pkg::t_rgba     r_mem [PALETTE_DEPTH];

    // Stage 1: decoded word and scaled position.
    logic                r1_valid;
    logic                r1_cmd;
    logic                r1_use_const;
    cmli_pkg::t_rgba     r1_const;
    logic [PW-1:0]       r1_pos;
    logic [7:0]          r1_entry_index;
    cmli_pkg::t_rgba     r1_entry_color;

    // Stage 2: palette data of both neighbors.
    logic                r2_valid;
    logic                r2_use_const;
    cmli_pkg::t_rgba     r2_const;
    logic [F-1:0]        r2_frac;
    cmli_pkg::t_rgba     r2_lo;
    cmli_pkg::t_rgba     r2_hi;

    // Stage 3: blend products.
    logic                r3_valid;
    logic                r3_direct;
    cmli_pkg::t_rgba     r3_color;
    logic signed [F+9:0] r3_prod [4];

    // Output buffer.
    cmli_pkg::t_rgba                  r_fifo [cmli_pkg::OUT_DEPTH];
    logic [cmli_pkg::OUT_PTR_W-1:0]   r_wr_ptr;
    logic [cmli_pkg::OUT_PTR_W-1:0]   r_rd_ptr;
    logic [cmli_pkg::OUT_CNT_W-1:0]   r_fcnt;
    logic [cmli_pkg::OUT_CNT_W-1:0]   r_cred;
    logic [cmli_pkg::OUT_CNT_W-1:0]   n_cred;

    logic                acc;
    logic                acc_map;
    logic                push;
    logic                pop;
    logic signed [CW-1:0] s_ext;
    logic                is_neg;
    logic                is_gt;
    logic [8:0]          size_eff;
    logic [8:0]          size_m1;
    logic                use_const;
    cmli_pkg::t_rgba     const_color;
    logic [F:0]          s_cl;
    logic [AW-1:0]       idx_lo;
    logic [AW-1:0]       idx_hi;
    logic                wr_en;
    logic signed [F+9:0] n3_prod [4];
    cmli_pkg::t_rgba     n_color;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign acc         = i_valid && !o_stall;
    assign acc_map     = acc && (i_cmd == cmli_pkg::CMD_MAP);
    assign o_stall     = (r_cred == cmli_pkg::OUT_CNT_W'(cmli_pkg::OUT_DEPTH));
    assign o_valid     = (r_fcnt != '0);
    assign pop         = o_valid && !i_stall;
    assign push        = r3_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= '0;
            r_clip_under   <= 1'b0;
            r_clip_over    <= 1'b0;
            r_under_color  <= cmli_pkg::OPAQUE_BLACK;
            r_over_color   <= cmli_pkg::OPAQUE_BLACK;
            r_mask_color   <= cmli_pkg::OPAQUE_BLACK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cmli_pkg::CFG_PALETTE_SIZE: r_palette_size <= i_cfg_data[8:0];
                cmli_pkg::CFG_CLIP_UNDER:   r_clip_under   <= i_cfg_data[0];
                cmli_pkg::CFG_CLIP_OVER:    r_clip_over    <= i_cfg_data[0];
                cmli_pkg::CFG_UNDER_COLOR:  r_under_color  <= i_cfg_data;
                cmli_pkg::CFG_OVER_COLOR:   r_over_color   <= i_cfg_data;
                cmli_pkg::CFG_MASK_COLOR:   r_mask_color   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the sample: either a fixed color, or a position in the palette.
    // A one-entry palette reads entry 0 through position zero.
    assign s_ext    = CW'(i_sample);
    assign is_neg   = s_ext[CW-1];
    assign is_gt    = (s_ext > ONE_C);
    assign size_eff = (r_palette_size > LIM_C) ? LIM_C : r_palette_size;
    assign size_m1  = size_eff - 9'd1;

    always_comb begin
        use_const   = 1'b0;
        const_color = cmli_pkg::OPAQUE_BLACK;
        s_cl        = '0;
        if (size_eff == 9'd0) begin
            use_const = 1'b1;
        end else if (size_eff == 9'd1) begin
            s_cl = '0;
        end else if (i_not_finite) begin
            use_const   = 1'b1;
            const_color = r_mask_color;
        end else if (is_neg) begin
            if (!r_clip_under) begin
                use_const   = 1'b1;
                const_color = r_under_color;
            end
        end else if (is_gt) begin
            if (r_clip_over) begin
                s_cl = ONE_U;
            end else begin
                use_const   = 1'b1;
                const_color = r_over_color;
            end
        end else begin
            s_cl = s_ext[F:0];
        end
    end

    // Stage 1 payload, with the position multiply.
    always_ff @(posedge i_clk) begin
        r1_cmd         <= i_cmd;
        r1_use_const   <= use_const;
        r1_const       <= const_color;
        r1_pos         <= PW'(s_cl) * PW'(size_m1);
        r1_entry_index <= i_entry_index;
        r1_entry_color <= i_entry_color;
    end

    // Neighbor addresses. The upper one is used only when the fraction is nonzero.
    assign idx_lo = AW'(r1_pos[PW-1:F]);
    assign idx_hi = idx_lo + AW'(1);
    assign wr_en  = r1_valid && (r1_cmd == cmli_pkg::CMD_WRITE)
                    && ({5'd0, r1_entry_index} < DEPTH_C);

    // Palette RAM. Writes and reads happen in the same stage, so each word
    // sees every write that was accepted before it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(r1_entry_index)] <= r1_entry_color;
        end
        r2_lo <= r_mem[idx_lo];
        r2_hi <= r_mem[idx_hi];
    end

    // Stage 2 payload.
    always_ff @(posedge i_clk) begin
        r2_use_const <= r1_use_const;
        r2_const     <= r1_const;
        r2_frac      <= r1_pos[F-1:0];
    end

    // Blend products per channel: (hi - lo) * frac.
    always_comb begin
        logic signed [8:0] diff;
        logic signed [F:0] fr;
        fr = $signed({1'b0, r2_frac});
        for (int ch = 0; ch < 4; ch++) begin
            diff        = $signed({1'b0, r2_hi[ch*8 +: 8]})
                          - $signed({1'b0, r2_lo[ch*8 +: 8]});
            n3_prod[ch] = diff * fr;
        end
    end

    // Stage 3 payload.
    always_ff @(posedge i_clk) begin
        r3_direct <= r2_use_const || (r2_frac == '0);
        r3_color  <= r2_use_const ? r2_const : r2_lo;
        for (int ch = 0; ch < 4; ch++) begin
            r3_prod[ch] <= n3_prod[ch];
        end
    end

    // Final add and round to nearest, ties up.
    always_comb begin
        logic signed [SW-1:0] sum;
        sum     = '0;
        n_color = r3_color;
        if (!r3_direct) begin
            for (int ch = 0; ch < 4; ch++) begin
                sum = $signed({3'b000, r3_color[ch*8 +: 8], {F{1'b0}}})
                      + SW'(r3_prod[ch]) + HALF_C;
                n_color[ch*8 +: 8] = sum[F+7:F];
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= acc;
            r2_valid <= r1_valid && (r1_cmd == cmli_pkg::CMD_MAP);
            r3_valid <= r2_valid;
        end
    end

    // Output buffer storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= n_color;
        end
    end

    // Output buffer pointers and the count of map words outstanding.
    assign n_cred = r_cred + cmli_pkg::OUT_CNT_W'(acc_map) - cmli_pkg::OUT_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
            r_cred   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + cmli_pkg::OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + cmli_pkg::OUT_PTR_W'(1);
            end
            r_fcnt <= r_fcnt + cmli_pkg::OUT_CNT_W'(push) - cmli_pkg::OUT_CNT_W'(pop);
            r_cred <= n_cred;
        end
    end

    assign o_red   = r_fifo[r_rd_ptr][31:24];
    assign o_green = r_fifo[r_rd_ptr][23:16];
    assign o_blue  = r_fifo[r_rd_ptr][15:8];
    assign o_alpha = r_fifo[r_rd_ptr][7:0];

    // Assertions.
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= cmli_pkg::OUT_CNT_W'(cmli_pkg::OUT_DEPTH))
        else $error("outstanding map count above buffer depth");

    a_fifo_within_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cred)
        else $error("buffered results exceed outstanding map words");

    a_map_reaches_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_map |-> ##3 push)
        else $error("map word did not reach the output buffer in three cycles");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fcnt != cmli_pkg::OUT_CNT_W'(cmli_pkg::OUT_DEPTH)) || pop)
        else $error("result pushed into a full output buffer");

    a_idle_when_no_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cred == '0) |-> !(o_valid || r2_valid || r3_valid))
        else $error("result in flight with no outstanding map word");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int PALETTE_DEPTH = 256;
    localparam int FRACTION_BITS = 16;
    localparam longint UNITY = longint'(1) << FRACTION_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    cmli_pkg::t_cfg_index i_cfg_index = cmli_pkg::CFG_PALETTE_SIZE;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_cmd = cmli_pkg::CMD_WRITE;
    logic signed [19:0] i_sample = '0;
    logic i_not_finite = 1'b0;
    logic [7:0] i_entry_index = '0;
    logic [31:0] i_entry_color = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic [7:0] o_alpha;

    // Mirror of the block's settings and palette.
    logic [8:0] map_size = '0;
    logic clamp_low = 1'b0;
    logic clamp_high = 1'b0;
    cmli_pkg::t_rgba low_color = cmli_pkg::OPAQUE_BLACK;
    cmli_pkg::t_rgba high_color = cmli_pkg::OPAQUE_BLACK;
    cmli_pkg::t_rgba nan_color = cmli_pkg::OPAQUE_BLACK;
    cmli_pkg::t_rgba palette_mirror [PALETTE_DEPTH];

    cmli_pkg::t_rgba pending_colors [$];
    int error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_until = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    string channel_names [4] = '{"red", "green", "blue", "alpha"};

    color_map_interpolated_lookup #(
        .PALETTE_DEPTH(PALETTE_DEPTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_sample(i_sample),
        .i_not_finite(i_not_finite),
        .i_entry_index(i_entry_index),
        .i_entry_color(i_entry_color),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue),
        .o_alpha(o_alpha)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter with a hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        i_stall <= (cycle_count < hold_until) || ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each result word against the oldest predicted color.
    always @(posedge i_clk) begin
        cmli_pkg::t_rgba want;
        cmli_pkg::t_rgba got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_red, o_green, o_blue, o_alpha};
            if (pending_colors.size() == 0) begin
                $error("unexpected result word %h", got);
                error_count++;
            end else begin
                want = pending_colors.pop_front();
                for (int ch = 0; ch < 4; ch++) begin
                    if (got[24 - 8 * ch +: 8] !== want[24 - 8 * ch +: 8]) begin
                        $error("%s mismatch: expected %0d, got %0d", channel_names[ch],
                               want[24 - 8 * ch +: 8], got[24 - 8 * ch +: 8]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Color that the block should give for one map word.
    function automatic cmli_pkg::t_rgba lookup_color(logic signed [19:0] value, logic nf);
        longint span;
        longint val;
        longint pos;
        longint frac;
        longint a;
        longint b;
        int idx;
        cmli_pkg::t_rgba lo;
        cmli_pkg::t_rgba hi;
        cmli_pkg::t_rgba mix;
        span = (map_size > PALETTE_DEPTH) ? PALETTE_DEPTH : map_size;
        if (span == 0) return cmli_pkg::OPAQUE_BLACK;
        if (span == 1) return palette_mirror[0];
        if (nf) return nan_color;
        val = value;
        if (clamp_low && val < 0) val = 0;
        if (clamp_high && val > UNITY) val = UNITY;
        if (val < 0) return low_color;
        if (val > UNITY) return high_color;
        // Split the scaled position into an entry and a blend weight.
        pos = val * (span - 1);
        idx = int'(pos >> FRACTION_BITS);
        frac = pos & (UNITY - 1);
        lo = palette_mirror[idx];
        if (frac == 0) return lo;
        hi = palette_mirror[idx + 1];
        mix = '0;
        for (int sh = 24; sh >= 0; sh -= 8) begin
            a = lo[sh +: 8];
            b = hi[sh +: 8];
            mix[sh +: 8] = 8'((a * (UNITY - frac) + b * frac + UNITY / 2) >> FRACTION_BITS);
        end
        return mix;
    endfunction

    function automatic cmli_pkg::t_rgba random_color();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Samples lean toward the zero to one range, with edges and outliers mixed in.
    function automatic logic signed [19:0] random_value();
        case ($urandom_range(9))
            0: return 20'($urandom());
            1: begin
                case ($urandom_range(6))
                    0: return 20'sd0;
                    1: return 20'(UNITY);
                    2: return 20'(UNITY - 1);
                    3: return 20'(UNITY + 1);
                    4: return -20'sd1;
                    5: return 20'h80000;
                    default: return 20'sd524287;
                endcase
            end
            2: return {1'b1, 19'($urandom())};
            3: return 20'($urandom_range(32'(UNITY) + 1, 524287));
            default: return 20'($urandom_range(0, 32'(UNITY)));
        endcase
    endfunction

    // Offer one input word and hold it until the block takes it.
    task automatic send_word(logic cmd, logic signed [19:0] value, logic nf,
                             logic [7:0] slot, cmli_pkg::t_rgba color);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_sample <= value;
        i_not_finite <= nf;
        i_entry_index <= slot;
        i_entry_color <= color;
        do @(posedge i_clk); while (o_stall);
        if (cmd == cmli_pkg::CMD_WRITE) begin
            palette_mirror[slot] = color;
        end else begin
            pending_colors.insert(pending_colors.size(), lookup_color(value, nf));
        end
    endtask

    task automatic map_word(logic signed [19:0] value, logic nf);
        send_word(cmli_pkg::CMD_MAP, value, nf, 8'($urandom()), $urandom());
    endtask

    task automatic write_entry(logic [7:0] slot, cmli_pkg::t_rgba color);
        send_word(cmli_pkg::CMD_WRITE, random_value(), 1'($urandom()), slot, color);
    endtask

    // Stop sending, let every result drain, then give the pipeline time to empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(cmli_pkg::t_cfg_index idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cmli_pkg::CFG_PALETTE_SIZE: map_size = data[8:0];
            cmli_pkg::CFG_CLIP_UNDER: clamp_low = data[0];
            cmli_pkg::CFG_CLIP_OVER: clamp_high = data[0];
            cmli_pkg::CFG_UNDER_COLOR: low_color = data;
            cmli_pkg::CFG_OVER_COLOR: high_color = data;
            cmli_pkg::CFG_MASK_COLOR: nan_color = data;
            default: ;
        endcase
    endtask

    // Full register update, only ever done on an idle block.
    task automatic set_config(logic [8:0] size, logic cu, logic co,
                              cmli_pkg::t_rgba uc, cmli_pkg::t_rgba oc,
                              cmli_pkg::t_rgba mc);
        wait_idle();
        write_register(cmli_pkg::CFG_PALETTE_SIZE, {23'b0, size});
        write_register(cmli_pkg::CFG_CLIP_UNDER, {31'b0, cu});
        write_register(cmli_pkg::CFG_CLIP_OVER, {31'b0, co});
        write_register(cmli_pkg::CFG_UNDER_COLOR, uc);
        write_register(cmli_pkg::CFG_OVER_COLOR, oc);
        write_register(cmli_pkg::CFG_MASK_COLOR, mc);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random config, then a run of mostly map words with some palette rewrites.
    task automatic run_segment(int n_items, logic [8:0] size);
        set_config(size, 1'($urandom()), 1'($urandom()),
                   random_color(), random_color(), random_color());
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 15) begin
                write_entry(8'($urandom()), $urandom());
            end else begin
                map_word(random_value(), $urandom_range(9) == 0);
            end
        end
    endtask

    // Reset state: an empty palette always maps to opaque black.
    task automatic test_empty_palette();
        map_word(20'sd0, 1'b0);
        map_word(20'sd0, 1'b1);
        map_word(20'h80000, 1'b0);
        map_word(20'sd524287, 1'b0);
    endtask

    // A one-entry palette returns entry zero for any sample.
    task automatic test_single_entry();
        write_entry(8'd0, 32'h1234_5678);
        set_config(9'd1, 1'b0, 1'b0, 32'hA0A1_A2A3, 32'hB0B1_B2B3, 32'hC0C1_C2C3);
        map_word(20'sd0, 1'b1);
        map_word(-20'sd1, 1'b0);
        map_word(20'sd524287, 1'b0);
    endtask

    // Mask, under, over, exact entries and a blend tie that must round up.
    task automatic test_blend_and_ranges();
        write_entry(8'd0, 32'h0000_FF10);
        write_entry(8'd1, 32'h01FF_0011);
        write_entry(8'd2, 32'hFF80_7FFF);
        set_config(9'd3, 1'b0, 1'b0, 32'hA0A1_A2A3, 32'hB0B1_B2B3, 32'hC0C1_C2C3);
        map_word(20'sd0, 1'b1);
        map_word(-20'sd1, 1'b0);
        map_word(20'(UNITY + 1), 1'b0);
        map_word(20'sd0, 1'b0);
        map_word(20'(UNITY), 1'b0);
        map_word(20'(UNITY / 2), 1'b0);
        map_word(20'(UNITY / 4), 1'b0);
        map_word(20'(UNITY * 3 / 4 - 1), 1'b0);
    endtask

    // With clipping on, out-of-range samples land on the end entries.
    task automatic test_clipping();
        set_config(9'd3, 1'b1, 1'b1, 32'hA0A1_A2A3, 32'hB0B1_B2B3, 32'hC0C1_C2C3);
        map_word(20'h80000, 1'b0);
        map_word(20'sd524287, 1'b0);
        map_word(-20'sd1, 1'b0);
        map_word(20'(UNITY + 1), 1'b0);
    endtask

    // Load every entry, then use the largest and an oversized palette size.
    task automatic test_full_palette();
        for (int n = 0; n < PALETTE_DEPTH; n++) begin
            write_entry(8'(n), random_color());
        end
        run_segment(40, 9'd256);
        run_segment(40, 9'd511);
    endtask

    // Long receiver hold-off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(9'd256, 1'b0, 1'b0, random_color(), random_color(), random_color());
        hold_until = cycle_count + 300;
        for (int n = 0; n < 60; n++) begin
            map_word(random_value(), 1'b0);
        end
        wait_idle();
    endtask

    // Several config settings under one idling pattern.
    task automatic test_idle_phase(int send_pct, int recv_pct);
        logic [8:0] size;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(9))
                0: size = 9'd0;
                1: size = 9'd1;
                2: size = 9'd2;
                3: size = 9'd256;
                4: size = 9'($urandom_range(257, 511));
                default: size = 9'($urandom_range(3, 255));
            endcase
            run_segment(55, size);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_palette();
        test_single_entry();
        test_blend_and_ranges();
        test_clipping();
        test_full_palette();
        test_backpressure();
        test_idle_phase(0, 0);
        test_idle_phase(57, 0);
        test_idle_phase(0, 57);
        test_idle_phase(9, 9);
        wait_idle();
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
